// ----- hw/rtl/lfsq_pkg.sv -----
// ---------------------------------------------------------------------------
// lfsq_pkg
// Shared widths, constants, types and helpers of the largest free square
// finder.
// ---------------------------------------------------------------------------
package lfsq_pkg;

    // fixed field widths
    localparam int SIDE_W = 11;
    localparam int POS_W  = 10;

    // grid side after reset
    localparam logic [SIDE_W-1:0] GRID_RESET = 11'd1024;

    // position flags of one cell, from the scan counters to the compute stage
    typedef struct packed {
        logic row_first;
        logic col_first;
        logic last;
    } lfsq_flags_t;

    // minimum of three square sides
    function automatic logic [SIDE_W-1:0] min3(
        input logic [SIDE_W-1:0] a,
        input logic [SIDE_W-1:0] b,
        input logic [SIDE_W-1:0] c
    );
        logic [SIDE_W-1:0] m;
        m = a;
        if (b < m)
        begin
            m = b;
        end
        if (c < m)
        begin
            m = c;
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/lfsq_if.sv -----
// ---------------------------------------------------------------------------
// lfsq_grid_if / lfsq_result_if
// Valid/ready channels: grid cells in, search result out.
// ---------------------------------------------------------------------------
interface lfsq_grid_if;
    import lfsq_pkg::*;

    logic valid;
    logic ready;
    logic cell_free;

    modport source (output valid, output cell_free, input ready);
    modport sink   (input valid, input cell_free, output ready);
endinterface

interface lfsq_result_if;
    import lfsq_pkg::*;

    logic              valid;
    logic              ready;
    logic [SIDE_W-1:0] best_side;
    logic [POS_W-1:0]  best_row;
    logic [POS_W-1:0]  best_col;

    modport source (output valid, output best_side, output best_row, output best_col,
                    input ready);
    modport sink   (input valid, input best_side, input best_row, input best_col,
                    output ready);
endinterface

// ----- hw/rtl/lfsq_ram.sv -----
// ---------------------------------------------------------------------------
// lfsq_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module lfsq_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- hw/rtl/lfsq_scan.sv -----
// ---------------------------------------------------------------------------
// lfsq_scan
// Grid side register and raster row/column counters; flags each accepted
// cell as first row, first column or last cell of the grid.
// ---------------------------------------------------------------------------
module lfsq_scan #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lfsq_pkg::SIDE_W-1:0] cfg_data,
    input  logic                        accept,
    output logic [$clog2(MAX_SIDE)-1:0] col,
    output logic [$clog2(MAX_SIDE)-1:0] row,
    output lfsq_pkg::lfsq_flags_t       flags
);
    import lfsq_pkg::*;

    localparam int COL_W = $clog2(MAX_SIDE);
    localparam int CW    = ((COL_W > SIDE_W) ? COL_W : SIDE_W) + 1;

    logic [SIDE_W-1:0] grid_reg, grid_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  row_reg, row_next;
    logic [CW-1:0]     grid_ext;
    logic [CW-1:0]     eff_n;
    logic              col_last;
    logic              row_last;

    // effective side: zero counts as one, clamp to the line store depth
    always_comb
    begin
        grid_ext = CW'(grid_reg);
        if (grid_reg == '0)
        begin
            eff_n = CW'(1);
        end
        else if (grid_ext > CW'(MAX_SIDE))
        begin
            eff_n = CW'(MAX_SIDE);
        end
        else
        begin
            eff_n = grid_ext;
        end
    end

    // end of row and end of grid
    assign col_last = (CW'(col_reg) + CW'(1)) >= eff_n;
    assign row_last = (CW'(row_reg) + CW'(1)) >= eff_n;

    assign flags.row_first = (row_reg == '0);
    assign flags.col_first = (col_reg == '0);
    assign flags.last      = col_last && row_last;
    assign col             = col_reg;
    assign row             = row_reg;

    // counter and register update
    always_comb
    begin
        grid_next = grid_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (cfg_we)
        begin
            grid_next = cfg_data;
            col_next  = '0;
            row_next  = '0;
        end
        else if (accept)
        begin
            if (col_last)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + COL_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg <= GRID_RESET;
            col_reg  <= '0;
            row_reg  <= '0;
        end
        else
        begin
            grid_reg <= grid_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
        end
    end
endmodule

// ----- hw/rtl/lfsq_core.sv -----
// ---------------------------------------------------------------------------
// lfsq_core
// Compute stage: takes the up side from the line store read, forms the
// cell's square side, writes it back, tracks the best square and holds the
// result word until it is taken.
// ---------------------------------------------------------------------------
module lfsq_core #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        accept,
    input  logic                        cell_free,
    input  logic [$clog2(MAX_SIDE)-1:0] col,
    input  logic [$clog2(MAX_SIDE)-1:0] row,
    input  lfsq_pkg::lfsq_flags_t       flags,
    output logic                        ready,
    input  logic [lfsq_pkg::SIDE_W-1:0] up_side,
    output logic                        wr_en,
    output logic [$clog2(MAX_SIDE)-1:0] wr_addr,
    output logic [lfsq_pkg::SIDE_W-1:0] wr_side,
    output logic                        res_valid,
    input  logic                        res_ready,
    output logic [lfsq_pkg::SIDE_W-1:0] res_side,
    output logic [lfsq_pkg::POS_W-1:0]  res_row,
    output logic [lfsq_pkg::POS_W-1:0]  res_col
);
    import lfsq_pkg::*;

    localparam int COL_W = $clog2(MAX_SIDE);

    // stage registers
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_free_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [COL_W-1:0]  s1_row_reg;
    lfsq_flags_t       s1_flags_reg;

    // running state
    logic [SIDE_W-1:0] left_reg, left_next;
    logic [SIDE_W-1:0] diag_reg, diag_next;
    logic [SIDE_W-1:0] best_side_reg, best_side_next;
    logic [COL_W-1:0]  best_row_reg, best_row_next;
    logic [COL_W-1:0]  best_col_reg, best_col_next;

    // result word
    logic              out_valid_reg, out_valid_next;
    logic [SIDE_W-1:0] out_side_reg;
    logic [POS_W-1:0]  out_row_reg;
    logic [POS_W-1:0]  out_col_reg;

    logic              s1_go;
    logic [SIDE_W-1:0] side;
    logic              better;
    logic [SIDE_W-1:0] cand_side;
    logic [COL_W-1:0]  cand_row;
    logic [COL_W-1:0]  cand_col;

    // stage advances unless the last cell meets a full, stalled result word
    assign s1_go = s1_valid_reg && !(s1_flags_reg.last && out_valid_reg && !res_ready);
    assign ready = !s1_valid_reg || s1_go;

    // square side of the current cell
    always_comb
    begin
        if (!s1_free_reg)
        begin
            side = '0;
        end
        else if (s1_flags_reg.row_first || s1_flags_reg.col_first)
        begin
            side = SIDE_W'(1);
        end
        else
        begin
            side = min3(up_side, left_reg, diag_reg) + SIDE_W'(1);
        end
    end

    // best record including the current cell, first occurrence wins
    assign better    = side > best_side_reg;
    assign cand_side = better ? side : best_side_reg;
    assign cand_row  = better ? s1_row_reg : best_row_reg;
    assign cand_col  = better ? s1_col_reg : best_col_reg;

    // line store write-back
    assign wr_en   = s1_go;
    assign wr_addr = s1_col_reg;
    assign wr_side = side;

    // stage occupancy
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // running state update
    always_comb
    begin
        left_next      = left_reg;
        diag_next      = diag_reg;
        best_side_next = best_side_reg;
        best_row_next  = best_row_reg;
        best_col_next  = best_col_reg;
        if (cfg_we)
        begin
            left_next      = '0;
            diag_next      = '0;
            best_side_next = '0;
            best_row_next  = '0;
            best_col_next  = '0;
        end
        else if (s1_go)
        begin
            if (s1_flags_reg.last)
            begin
                left_next      = '0;
                diag_next      = '0;
                best_side_next = '0;
                best_row_next  = '0;
                best_col_next  = '0;
            end
            else
            begin
                left_next      = side;
                diag_next      = up_side;
                best_side_next = cand_side;
                best_row_next  = cand_row;
                best_col_next  = cand_col;
            end
        end
    end

    // result word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go && s1_flags_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            left_reg      <= '0;
            diag_reg      <= '0;
            best_side_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
            diag_reg      <= diag_next;
            best_side_reg <= best_side_next;
            best_row_reg  <= best_row_next;
            best_col_reg  <= best_col_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_free_reg  <= cell_free;
            s1_col_reg   <= col;
            s1_row_reg   <= row;
            s1_flags_reg <= flags;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_flags_reg.last)
        begin
            out_side_reg <= cand_side;
            out_row_reg  <= POS_W'(cand_row);
            out_col_reg  <= POS_W'(cand_col);
        end
    end

    assign res_valid = out_valid_reg;
    assign res_side  = out_side_reg;
    assign res_row   = out_row_reg;
    assign res_col   = out_col_reg;
endmodule

// ----- hw/rtl/largest_free_square_finder_top.sv -----
// ---------------------------------------------------------------------------
// largest_free_square_finder_top
// Raster scan of a square grid for the largest all-free square.
// ---------------------------------------------------------------------------
// Usage:
// - grid: one word per cell (cell_free), row-major, grid_side x grid_side
//   cells per grid; a new grid starts right after the last cell.
// - result: one word per grid with best_side, best_row, best_col (bottom-right
//   corner of the first largest square in raster order; all zero when the
//   grid has no free cell).
// - cfg_we/cfg_data: write grid_side (0 counts as 1, clamped to MAX_SIDE);
//   a write restarts the scan at row 0, column 0. Write only while idle.
// Throughput: one cell per cycle unless the compute stage stalls (see Stall).
// A cell is accepted together with the line store read of its column; the
// compute stage forms the side from the read data and writes it back through
// the second RAM port, and the last cell of a grid then loads the result word.
// Reset: grid side 1024, counters and best record cleared, no result pending.
// Line store contents are not cleared; every row writes before the next reads.
// Stall: a pending result word is held stable; cells keep flowing until the
// last cell of the next grid reaches the compute stage.
// ---------------------------------------------------------------------------
module largest_free_square_finder_top #(
    parameter int MAX_SIDE = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [lfsq_pkg::SIDE_W-1:0] cfg_data,
    lfsq_grid_if.sink                   grid,
    lfsq_result_if.source               result
);
    import lfsq_pkg::*;

    localparam int COL_W = $clog2(MAX_SIDE);

    logic              accept;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  row;
    lfsq_flags_t       flags;
    logic              core_ready;
    logic [SIDE_W-1:0] up_side;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [SIDE_W-1:0] wr_side;

    // input handshake
    assign grid.ready = core_ready;
    assign accept     = grid.valid && core_ready;

    // raster counters
    lfsq_scan #(
        .MAX_SIDE (MAX_SIDE)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .col      (col),
        .row      (row),
        .flags    (flags)
    );

    // line store of the previous row's sides
    lfsq_ram #(
        .WIDTH (SIDE_W),
        .DEPTH (MAX_SIDE)
    ) u_line (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_side),
        .re    (accept),
        .raddr (col),
        .rdata (up_side)
    );

    // side computation and best tracking
    lfsq_core #(
        .MAX_SIDE (MAX_SIDE)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .accept    (accept),
        .cell_free (grid.cell_free),
        .col       (col),
        .row       (row),
        .flags     (flags),
        .ready     (core_ready),
        .up_side   (up_side),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_side   (wr_side),
        .res_valid (result.valid),
        .res_ready (result.ready),
        .res_side  (result.best_side),
        .res_row   (result.best_row),
        .res_col   (result.best_col)
    );
endmodule

// ----- hw/rtl/lfsq_checker.sv -----
// ---------------------------------------------------------------------------
// lfsq_checker
// Port-level checks of the result channel, bound to the top level.
// ---------------------------------------------------------------------------
module lfsq_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [lfsq_pkg::SIDE_W-1:0] best_side,
    input logic [lfsq_pkg::POS_W-1:0]  best_row,
    input logic [lfsq_pkg::POS_W-1:0]  best_col
);
    import lfsq_pkg::*;

    // stalled result word stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // stalled result word keeps its payload
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(best_side) && $stable(best_row)
                                    && $stable(best_col))
        else $error("result payload changed while stalled");

    // a grid without free cells reports the origin
    a_empty_origin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (best_side == '0) |-> (best_row == '0) && (best_col == '0))
        else $error("empty grid reported a nonzero position");
endmodule

bind largest_free_square_finder_top lfsq_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .best_side (result.best_side),
    .best_row  (result.best_row),
    .best_col  (result.best_col)
);

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Drives raster grids of free and obstacle cells into the largest free
// square finder, predicts the side and bottom-right corner of the first
// largest all-free square of each grid, and compares every result word.
// ---------------------------------------------------------------------------
module testbench;
    import lfsq_pkg::*;

    localparam int MAX_SIDE      = 1024;
    localparam int MAX_GAP       = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int SQUEEZE_HOLD  = 300;
    localparam int RANDOM_CELLS  = 1750;
    localparam int RANDOM_GRIDS  = 40;

    // one pending stimulus word: a grid cell or a grid_side write
    typedef struct {
        bit                is_setting;
        bit                calm;
        bit                squeeze;
        logic [SIDE_W-1:0] value;
    } stim_t;

    // expected square of one grid
    typedef struct {
        logic [SIDE_W-1:0] side;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
    } square_t;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              cfg_we   = 1'b0;
    logic [SIDE_W-1:0] cfg_data = '0;

    lfsq_grid_if   grid_ch();
    lfsq_result_if result_ch();

    largest_free_square_finder_top #(
        .MAX_SIDE (MAX_SIDE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .grid     (grid_ch),
        .result   (result_ch)
    );

    stim_t   pending_words[$];
    square_t expected_squares[$];

    // scan state of the predictor
    logic [SIDE_W-1:0] up_sides [MAX_SIDE] = '{default: '0};
    logic [SIDE_W-1:0] grid_side_reg = GRID_RESET;
    int                left_side;
    int                diag_side;
    int                scan_row;
    int                scan_col;
    int                best_side;
    int                best_row;
    int                best_col;

    // handshake bookkeeping
    int squares_predicted = 0;
    int squares_checked   = 0;
    int squeeze_req       = 0;
    int squeeze_done      = 0;
    int failures          = 0;
    int cell_gap          = 0;
    int settle            = SETTLE_CYCLES;
    int result_stall      = 0;
    int result_hold       = 0;
    bit calm              = 1'b0;
    int cells_queued      = 0;
    int grids_queued      = 0;

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // drop the grid in progress and start again at row 0, column 0
    function automatic void restart_scan();
        left_side = 0;
        diag_side = 0;
        scan_row  = 0;
        scan_col  = 0;
        best_side = 0;
        best_row  = 0;
        best_col  = 0;
    endfunction

    // advance the predicted scan by one accepted cell
    function automatic void scan_cell(logic free);
        int      n;
        int      c;
        int      up;
        int      m;
        int      s;
        square_t sq;
        n = grid_side_reg;
        if (n == 0)
        begin
            n = 1;
        end
        if (n > MAX_SIDE)
        begin
            n = MAX_SIDE;
        end
        c = (scan_col >= MAX_SIDE) ? MAX_SIDE - 1 : scan_col;
        up = up_sides[c];
        if (!free)
        begin
            s = 0;
        end
        else if (scan_row == 0 || c == 0)
        begin
            s = 1;
        end
        else
        begin
            m = (up < left_side) ? up : left_side;
            m = (diag_side < m) ? diag_side : m;
            s = (m + 1) % (1 << SIDE_W);
        end
        // the old up value is the up-left value of the next cell
        diag_side  = up;
        left_side  = s;
        up_sides[c] = s[SIDE_W-1:0];
        if (s > best_side)
        begin
            best_side = s;
            best_row  = scan_row;
            best_col  = c;
        end
        if (c + 1 >= n)
        begin
            scan_col = 0;
            if (scan_row + 1 >= n)
            begin
                sq.side = best_side[SIDE_W-1:0];
                sq.row  = best_row[POS_W-1:0];
                sq.col  = best_col[POS_W-1:0];
                expected_squares.push_back(sq);
                squares_predicted++;
                restart_scan();
            end
            else
            begin
                scan_row = scan_row + 1;
            end
        end
        else
        begin
            scan_col = c + 1;
        end
    endfunction

    // queue a grid_side write that opens a new phase
    task automatic add_setting(int side, bit quiet, bit squeeze);
        stim_t w;
        w.is_setting = 1'b1;
        w.calm       = quiet;
        w.squeeze    = squeeze;
        w.value      = side[SIDE_W-1:0];
        pending_words.push_back(w);
    endtask

    task automatic add_cell(logic free);
        stim_t w;
        w.is_setting = 1'b0;
        w.calm       = 1'b0;
        w.squeeze    = 1'b0;
        w.value      = {{(SIDE_W-1){1'b0}}, free};
        pending_words.push_back(w);
        cells_queued++;
    endtask

    // cells of a small grid, row-major from the lsb
    task automatic add_grid_bits(int side, logic [63:0] bits);
        for (int i = 0; i < side * side; i++)
        begin
            add_cell(bits[i]);
        end
        grids_queued++;
    endtask

    // grid of random cells, free with the given percentage
    task automatic add_grid_random(int side, int free_pct);
        for (int i = 0; i < side * side; i++)
        begin
            add_cell($urandom_range(0, 99) < free_pct);
        end
        grids_queued++;
    endtask

    // cell driver: one word per handshake, grid_side writes only when drained
    always @(posedge clk)
    begin : drive_cells
        logic  nxt_valid;
        logic  nxt_cell;
        logic  nxt_we;
        stim_t w;
        nxt_valid = grid_ch.valid;
        nxt_cell  = grid_ch.cell_free;
        nxt_we    = 1'b0;
        if (rst_n)
        begin
            if (grid_ch.valid && grid_ch.ready)
            begin
                scan_cell(grid_ch.cell_free);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && pending_words.size() > 0)
            begin
                if (cell_gap > 0)
                begin
                    cell_gap--;
                end
                else if (pending_words[0].is_setting)
                begin
                    // every result in and the pipeline settled
                    if (squares_predicted == squares_checked && !result_ch.valid)
                    begin
                        if (settle > 0)
                        begin
                            settle--;
                        end
                        else
                        begin
                            w = pending_words.pop_front();
                            nxt_we = 1'b1;
                            cfg_data <= w.value;
                            grid_side_reg = w.value;
                            restart_scan();
                            calm <= w.calm;
                            if (w.squeeze)
                            begin
                                squeeze_req++;
                            end
                            settle = SETTLE_CYCLES;
                        end
                    end
                end
                else
                begin
                    w = pending_words.pop_front();
                    nxt_valid = 1'b1;
                    nxt_cell  = w.value[0];
                    cell_gap  = calm ? 0 : $urandom_range(0, MAX_GAP);
                end
            end
        end
        grid_ch.valid     <= nxt_valid;
        grid_ch.cell_free <= nxt_cell;
        cfg_we            <= nxt_we;
    end

    // result monitor: compare each word with the oldest expected square
    always @(posedge clk)
    begin : check_results
        logic    nxt_ready;
        square_t sq;
        nxt_ready = result_ch.ready;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                nxt_ready = 1'b0;
                if (expected_squares.size() == 0)
                begin
                    $error("result word with no grid pending: side %0d row %0d col %0d",
                           result_ch.best_side, result_ch.best_row, result_ch.best_col);
                    failures++;
                end
                else
                begin
                    sq = expected_squares.pop_front();
                    squares_checked <= squares_checked + 1;
                    if (sq.side !== result_ch.best_side)
                    begin
                        $error("best_side: expected %0d, got %0d", sq.side,
                               result_ch.best_side);
                        failures++;
                    end
                    if (sq.row !== result_ch.best_row)
                    begin
                        $error("best_row: expected %0d, got %0d", sq.row,
                               result_ch.best_row);
                        failures++;
                    end
                    if (sq.col !== result_ch.best_col)
                    begin
                        $error("best_col: expected %0d, got %0d", sq.col,
                               result_ch.best_col);
                        failures++;
                    end
                end
                // long hold-off once, so the block fills and stalls its input
                if (squeeze_req != squeeze_done)
                begin
                    result_hold  = SQUEEZE_HOLD;
                    squeeze_done = squeeze_done + 1;
                end
                result_stall = calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!nxt_ready)
            begin
                if (result_hold > 0)
                begin
                    result_hold--;
                end
                else if (result_stall > 0)
                begin
                    if (result_ch.valid)
                    begin
                        result_stall--;
                    end
                end
                else
                begin
                    nxt_ready = 1'b1;
                end
            end
        end
        result_ch.ready <= nxt_ready;
    end

    // stimulus and end of run
    initial
    begin
        int side;
        int grids;
        int pct;
        grid_ch.valid     = 1'b0;
        grid_ch.cell_free = 1'b0;
        result_ch.ready   = 1'b0;
        restart_scan();

        // directed: dropped scans at the widest settings
        add_setting(2047, 1'b0, 1'b0);
        add_grid_bits(0, '0);
        add_cell(1'b1);
        add_cell(1'b1);
        add_setting(1024, 1'b0, 1'b0);
        add_cell(1'b1);
        add_cell(1'b0);
        // single-cell grids: no free cell, then one free cell
        add_setting(1, 1'b0, 1'b0);
        add_grid_bits(1, 64'h0);
        add_grid_bits(1, 64'h1);
        // side zero counts as one
        add_setting(0, 1'b0, 1'b0);
        add_grid_bits(1, 64'h1);
        add_grid_bits(1, 64'h0);
        // tie on the diagonal keeps the first corner
        add_setting(2, 1'b0, 1'b0);
        add_grid_bits(2, 64'h9);
        // write in mid-scan drops the grid, then a fully free grid
        add_setting(3, 1'b0, 1'b0);
        add_cell(1'b0);
        add_cell(1'b0);
        add_setting(3, 1'b0, 1'b0);
        add_grid_bits(3, 64'h1FF);

        // squeeze: small grids while the receiver holds off
        add_setting(2, 1'b0, 1'b1);
        for (int g = 0; g < 16; g++)
        begin
            add_grid_random(2, 75);
        end

        // random phases, mostly small grids, now and then a larger one
        cells_queued = 0;
        grids_queued = 0;
        while (cells_queued < RANDOM_CELLS || grids_queued < RANDOM_GRIDS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                side  = $urandom_range(11, 24);
                grids = 1;
            end
            else
            begin
                side  = $urandom_range(1, 10);
                grids = $urandom_range(1, 6);
            end
            add_setting(side, $urandom_range(0, 3) == 0, 1'b0);
            for (int g = 0; g < grids; g++)
            begin
                pct = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(40, 100);
                add_grid_random(side, pct);
            end
        end

        // reset
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // wait for every word to be moved and every square to be checked
        while (pending_words.size() != 0 || grid_ch.valid
               || squares_predicted != squares_checked)
        begin
            @(negedge clk);
        end
        repeat (10) @(posedge clk);
        if (failures == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #10000000;
        $display("FAILURE");
        $finish;
    end

endmodule
